// ===== rtl/marching_squares_cell_assert.svh =====
// assertion macros shared by the marching squares cell rtl
// no dependencies; expects signals clock and reset in the using module
`ifndef MARCHING_SQUARES_CELL_ASSERT_SVH
`define MARCHING_SQUARES_CELL_ASSERT_SVH

// same-cycle implication
`define MSQ_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define MSQ_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/msq_pkg.sv =====
// shared widths, register indexes, case codes, types and a saturation function for the cell pipeline
// no dependencies
package msq_pkg;

   localparam int CRD_W     = 32;
   localparam int STEP_W    = 31;
   localparam int IDX_W     = 8;
   localparam int CASE_W    = 4;
   localparam int CSR_IDX_W = 2;
   localparam int DIV_STEPS = 35;
   localparam int EDGE_LAT  = DIV_STEPS + 4;

   localparam logic [CSR_IDX_W-1:0] REG_ORIGIN_X = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_ORIGIN_Y = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_STEP_X   = 2'd2;
   localparam logic [CSR_IDX_W-1:0] REG_STEP_Y   = 2'd3;

   localparam logic [CASE_W-1:0] CASE_NONE     = 4'd0;
   localparam logic [CASE_W-1:0] CASE_ALL      = 4'd15;
   localparam logic [CASE_W-1:0] CASE_SADDLE_A = 4'd5;
   localparam logic [CASE_W-1:0] CASE_SADDLE_B = 4'd10;

   typedef struct packed {
      logic [32:0] rem;
      logic [DIV_STEPS-1:0] low;
      logic [DIV_STEPS-1:0] quo;
      logic [32:0] dmag;
      logic neg;
      logic ovf;
      logic eq;
      logic signed [CRD_W-1:0] c1;
   } div_stage_type;

   typedef struct packed {
      logic [CASE_W-1:0] code;
      logic signed [CRD_W-1:0] x0;
      logic signed [CRD_W-1:0] x1;
      logic signed [CRD_W-1:0] y0;
      logic signed [CRD_W-1:0] y1;
   } cell_info_type;

   typedef struct packed {
      logic signed [CRD_W-1:0] sx;
      logic signed [CRD_W-1:0] sy;
      logic signed [CRD_W-1:0] ex;
      logic signed [CRD_W-1:0] ey;
   } seg_type;

   typedef struct packed {
      logic hold;
   } route_stat_type;

   function automatic logic signed [CRD_W-1:0] sat32(input logic signed [40:0] v);
      logic signed [40:0] hi_lim;
      logic signed [40:0] lo_lim;
      hi_lim = 41'sd2147483647;
      lo_lim = -41'sd2147483648;
      if (v > hi_lim) begin
         return 32'sh7fffffff;
      end else if (v < lo_lim) begin
         return 32'sh80000000;
      end
      return v[CRD_W-1:0];
   endfunction

endpackage

// ===== rtl/marching_squares_cell.sv =====
// throughput: one cell per cycle unless stalled; saddle cells send two beats, stalling the input
// rate is set by the output register, which sends one segment beat per cycle while not stalled
// dividers: 35-stage restoring pipelines, one quotient bit per stage, four in parallel
// reset: synchronous, clears all valid bits and loads origin 0 and steps of 1.0
// depends on msq_pkg, msq_corner, msq_edge, msq_route
module marching_squares_cell import msq_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_write,
   input  logic [CSR_IDX_W-1:0]    csr_index,
   input  logic [CRD_W-1:0]        csr_wdata,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [IDX_W-1:0]        req_cell_col,
   input  logic [IDX_W-1:0]        req_cell_row,
   input  logic signed [CRD_W-1:0] req_value_lower_left,
   input  logic signed [CRD_W-1:0] req_value_lower_right,
   input  logic signed [CRD_W-1:0] req_value_upper_right,
   input  logic signed [CRD_W-1:0] req_value_upper_left,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic signed [CRD_W-1:0] rsp_start_x,
   output logic signed [CRD_W-1:0] rsp_start_y,
   output logic signed [CRD_W-1:0] rsp_end_x,
   output logic signed [CRD_W-1:0] rsp_end_y,
   output logic [CASE_W-1:0]       rsp_case_code,
   output logic                    rsp_last_segment
);

   logic signed [CRD_W-1:0] org_x_ff, org_y_ff;
   logic [STEP_W-1:0] stp_x_ff, stp_y_ff;
   logic adv;
   route_stat_type stat;

   logic vld_a_ff, vld_b_ff, vld_c_ff;
   logic [CASE_W-1:0] code_a_ff, code_b_ff, code_c_ff, code_in;
   logic [IDX_W-1:0] col_a_ff, row_a_ff;
   logic signed [CRD_W-1:0] v_a_ff [4];
   logic signed [CRD_W-1:0] v_b_ff [4];
   logic signed [CRD_W-1:0] v_c_ff [4];
   logic signed [CRD_W-1:0] x0, x1, y0, y1;
   logic signed [CRD_W-1:0] bx, ry, tx, ly;
   logic [EDGE_LAT-1:0] vld_dly_ff;
   cell_info_type info_dly_ff [EDGE_LAT];

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         org_x_ff <= '0;
         org_y_ff <= '0;
         stp_x_ff <= 31'd65536;
         stp_y_ff <= 31'd65536;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_ORIGIN_X: org_x_ff <= csr_wdata;
            REG_ORIGIN_Y: org_y_ff <= csr_wdata;
            REG_STEP_X:   stp_x_ff <= csr_wdata[STEP_W-1:0];
            REG_STEP_Y:   stp_y_ff <= csr_wdata[STEP_W-1:0];
            default: ;
         endcase
      end
   end

   assign adv       = ~stat.hold;
   assign req_stall = ~adv;

   assign code_in = {req_value_upper_left > 0, req_value_upper_right > 0,
                     req_value_lower_right > 0, req_value_lower_left > 0};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_a_ff   <= 1'b0;
         vld_b_ff   <= 1'b0;
         vld_c_ff   <= 1'b0;
         vld_dly_ff <= '0;
      end else if (adv) begin
         vld_a_ff   <= req_valid & (code_in != CASE_NONE) & (code_in != CASE_ALL);
         vld_b_ff   <= vld_a_ff;
         vld_c_ff   <= vld_b_ff;
         vld_dly_ff <= {vld_dly_ff[EDGE_LAT-2:0], vld_c_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         col_a_ff  <= req_cell_col;
         row_a_ff  <= req_cell_row;
         code_a_ff <= code_in;
         v_a_ff[0] <= req_value_lower_left;
         v_a_ff[1] <= req_value_lower_right;
         v_a_ff[2] <= req_value_upper_right;
         v_a_ff[3] <= req_value_upper_left;
         code_b_ff <= code_a_ff;
         v_b_ff    <= v_a_ff;
         code_c_ff <= code_b_ff;
         v_c_ff    <= v_b_ff;
         info_dly_ff[0] <= '{code: code_c_ff, x0: x0, x1: x1, y0: y0, y1: y1};
         for (int k = 1; k < EDGE_LAT; k++) begin
            info_dly_ff[k] <= info_dly_ff[k-1];
         end
      end
   end

   msq_corner u_corner_x (
      .clock(clock), .adv(adv), .idx(col_a_ff), .origin(org_x_ff), .step(stp_x_ff),
      .lo(x0), .hi(x1)
   );

   msq_corner u_corner_y (
      .clock(clock), .adv(adv), .idx(row_a_ff), .origin(org_y_ff), .step(stp_y_ff),
      .lo(y0), .hi(y1)
   );

   // bottom, right, top, left edges
   msq_edge u_edge_b (
      .clock(clock), .adv(adv), .a(v_c_ff[0]), .b(v_c_ff[1]), .c1(x0), .c2(x1), .res(bx)
   );

   msq_edge u_edge_r (
      .clock(clock), .adv(adv), .a(v_c_ff[1]), .b(v_c_ff[2]), .c1(y0), .c2(y1), .res(ry)
   );

   msq_edge u_edge_t (
      .clock(clock), .adv(adv), .a(v_c_ff[3]), .b(v_c_ff[2]), .c1(x0), .c2(x1), .res(tx)
   );

   msq_edge u_edge_l (
      .clock(clock), .adv(adv), .a(v_c_ff[0]), .b(v_c_ff[3]), .c1(y0), .c2(y1), .res(ly)
   );

   msq_route u_route (
      .clock(clock),
      .reset(reset),
      .tail_vld(vld_dly_ff[EDGE_LAT-1]),
      .info(info_dly_ff[EDGE_LAT-1]),
      .bx(bx),
      .ry(ry),
      .tx(tx),
      .ly(ly),
      .rsp_stall(rsp_stall),
      .rsp_valid(rsp_valid),
      .rsp_start_x(rsp_start_x),
      .rsp_start_y(rsp_start_y),
      .rsp_end_x(rsp_end_x),
      .rsp_end_y(rsp_end_y),
      .rsp_case_code(rsp_case_code),
      .rsp_last_segment(rsp_last_segment),
      .stat(stat)
   );

endmodule

// ===== rtl/msq_corner.sv =====
// corner coordinate pair for one axis: origin + index * step, saturated
// depends on msq_pkg
module msq_corner import msq_pkg::*; (
   input  logic                    clock,
   input  logic                    adv,
   input  logic [IDX_W-1:0]        idx,
   input  logic signed [CRD_W-1:0] origin,
   input  logic [STEP_W-1:0]       step,
   output logic signed [CRD_W-1:0] lo,
   output logic signed [CRD_W-1:0] hi
);

   logic [39:0] p_lo_ff, p_lo_in, p_hi_ff, p_hi_in;
   logic signed [CRD_W-1:0] lo_ff, lo_in, hi_ff, hi_in;
   logic signed [40:0] org_ext;

   always_comb begin
      p_lo_in = {32'd0, idx} * {9'd0, step};
      p_hi_in = ({32'd0, idx} + 40'd1) * {9'd0, step};
      org_ext = {{9{origin[CRD_W-1]}}, origin};
      lo_in   = sat32(org_ext + $signed({1'b0, p_lo_ff}));
      hi_in   = sat32(org_ext + $signed({1'b0, p_hi_ff}));
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         p_lo_ff <= p_lo_in;
         p_hi_ff <= p_hi_in;
         lo_ff   <= lo_in;
         hi_ff   <= hi_in;
      end
   end

   assign lo = lo_ff;
   assign hi = hi_ff;

endmodule

// ===== rtl/msq_edge.sv =====
// zero crossing on one cell edge: c1 + (-a)(c2-c1)/(b-a), restoring divider
// one quotient bit per stage; depends on msq_pkg
module msq_edge import msq_pkg::*; (
   input  logic                    clock,
   input  logic                    adv,
   input  logic signed [CRD_W-1:0] a,
   input  logic signed [CRD_W-1:0] b,
   input  logic signed [CRD_W-1:0] c1,
   input  logic signed [CRD_W-1:0] c2,
   output logic signed [CRD_W-1:0] res
);

   // difference stage
   logic signed [32:0] den_ff, nega_ff, dc_ff;
   logic eq1_ff;
   logic signed [CRD_W-1:0] c1a_ff;
   // product stage
   logic signed [65:0] num_ff;
   logic signed [32:0] den2_ff;
   logic eq2_ff;
   logic signed [CRD_W-1:0] c1b_ff;
   // divider
   div_stage_type div_ff [0:DIV_STEPS];
   div_stage_type div_in [0:DIV_STEPS];
   logic [63:0] nmag;
   logic [32:0] dmag;
   logic signed [CRD_W-1:0] res_ff, res_in;
   logic [35:0] qm;
   logic signed [36:0] qs;
   logic signed [40:0] sum;

   always_ff @(posedge clock) begin
      if (adv) begin
         den_ff  <= $signed({b[CRD_W-1], b}) - $signed({a[CRD_W-1], a});
         nega_ff <= -$signed({a[CRD_W-1], a});
         dc_ff   <= $signed({c2[CRD_W-1], c2}) - $signed({c1[CRD_W-1], c1});
         eq1_ff  <= (a == b);
         c1a_ff  <= c1;
         num_ff  <= $signed({{33{nega_ff[32]}}, nega_ff}) * $signed({{33{dc_ff[32]}}, dc_ff});
         den2_ff <= den_ff;
         eq2_ff  <= eq1_ff;
         c1b_ff  <= c1a_ff;
      end
   end

   always_comb begin
      nmag = num_ff[65] ? 64'(-num_ff) : num_ff[63:0];
      dmag = den2_ff[32] ? 33'(-den2_ff) : den2_ff;
      div_in[0].rem  = {4'd0, nmag[63:DIV_STEPS]};
      div_in[0].low  = nmag[DIV_STEPS-1:0];
      div_in[0].quo  = '0;
      div_in[0].dmag = dmag;
      div_in[0].neg  = num_ff[65] ^ den2_ff[32];
      div_in[0].ovf  = ({4'd0, nmag[63:DIV_STEPS]} >= dmag);
      div_in[0].eq   = eq2_ff;
      div_in[0].c1   = c1b_ff;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         div_ff[0] <= div_in[0];
      end
   end

   for (genvar g = 0; g < DIV_STEPS; g++) begin : g_div
      logic [33:0] t;
      logic ge;
      always_comb begin
         t  = {div_ff[g].rem, div_ff[g].low[DIV_STEPS-1]};
         ge = (t >= {1'b0, div_ff[g].dmag});
         div_in[g+1]      = div_ff[g];
         div_in[g+1].rem  = ge ? 33'(t - {1'b0, div_ff[g].dmag}) : t[32:0];
         div_in[g+1].low  = {div_ff[g].low[DIV_STEPS-2:0], 1'b0};
         div_in[g+1].quo  = {div_ff[g].quo[DIV_STEPS-2:0], ge};
      end
      always_ff @(posedge clock) begin
         if (adv) begin
            div_ff[g+1] <= div_in[g+1];
         end
      end
   end

   always_comb begin
      if (div_ff[DIV_STEPS].ovf || ({1'b0, div_ff[DIV_STEPS].quo} > 36'd17179869184)) begin
         qm = 36'd17179869184;
      end else begin
         qm = {1'b0, div_ff[DIV_STEPS].quo};
      end
      qs  = div_ff[DIV_STEPS].neg ? -$signed({1'b0, qm}) : $signed({1'b0, qm});
      sum = $signed({{9{div_ff[DIV_STEPS].c1[CRD_W-1]}}, div_ff[DIV_STEPS].c1})
            + $signed({{4{qs[36]}}, qs});
      res_in = div_ff[DIV_STEPS].eq ? div_ff[DIV_STEPS].c1 : sat32(sum);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         res_ff <= res_in;
      end
   end

   assign res = res_ff;

endmodule

// ===== rtl/msq_route.sv =====
// segment routing and output register, two beats for saddle cells
// depends on msq_pkg and marching_squares_cell_assert.svh
`include "marching_squares_cell_assert.svh"
module msq_route import msq_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    tail_vld,
   input  cell_info_type           info,
   input  logic signed [CRD_W-1:0] bx,
   input  logic signed [CRD_W-1:0] ry,
   input  logic signed [CRD_W-1:0] tx,
   input  logic signed [CRD_W-1:0] ly,
   input  logic                    rsp_stall,
   output logic                    rsp_valid,
   output logic signed [CRD_W-1:0] rsp_start_x,
   output logic signed [CRD_W-1:0] rsp_start_y,
   output logic signed [CRD_W-1:0] rsp_end_x,
   output logic signed [CRD_W-1:0] rsp_end_y,
   output logic [CASE_W-1:0]       rsp_case_code,
   output logic                    rsp_last_segment,
   output route_stat_type          stat
);

   logic vld_ff, vld_in, beat_ff, beat_in, two_ff, two_in;
   seg_type seg0_ff, seg0_in, seg1_ff, seg1_in;
   logic [CASE_W-1:0] code_ff, code_in;
   seg_type p_l, p_b, p_r, p_t;
   logic last, take, load;

   always_comb begin
      p_l = '{sx: info.x0, sy: ly, ex: info.x0, ey: ly};
      p_b = '{sx: bx, sy: info.y0, ex: bx, ey: info.y0};
      p_r = '{sx: info.x1, sy: ry, ex: info.x1, ey: ry};
      p_t = '{sx: tx, sy: info.y1, ex: tx, ey: info.y1};
      seg0_in = '{sx: p_l.sx, sy: p_l.sy, ex: p_b.ex, ey: p_b.ey};
      seg1_in = '{sx: p_r.sx, sy: p_r.sy, ex: p_t.ex, ey: p_t.ey};
      two_in  = 1'b0;
      case (info.code) inside
         4'd1, 4'd14: seg0_in = '{sx: p_l.sx, sy: p_l.sy, ex: p_b.ex, ey: p_b.ey};
         4'd2, 4'd13: seg0_in = '{sx: p_b.sx, sy: p_b.sy, ex: p_r.ex, ey: p_r.ey};
         4'd4, 4'd11: seg0_in = '{sx: p_r.sx, sy: p_r.sy, ex: p_t.ex, ey: p_t.ey};
         4'd7, 4'd8:  seg0_in = '{sx: p_t.sx, sy: p_t.sy, ex: p_l.ex, ey: p_l.ey};
         4'd3, 4'd12: seg0_in = '{sx: p_l.sx, sy: p_l.sy, ex: p_r.ex, ey: p_r.ey};
         4'd6, 4'd9:  seg0_in = '{sx: p_b.sx, sy: p_b.sy, ex: p_t.ex, ey: p_t.ey};
         CASE_SADDLE_A: begin
            seg0_in = '{sx: p_b.sx, sy: p_b.sy, ex: p_l.ex, ey: p_l.ey};
            seg1_in = '{sx: p_r.sx, sy: p_r.sy, ex: p_t.ex, ey: p_t.ey};
            two_in  = 1'b1;
         end
         CASE_SADDLE_B: begin
            seg0_in = '{sx: p_b.sx, sy: p_b.sy, ex: p_r.ex, ey: p_r.ey};
            seg1_in = '{sx: p_t.sx, sy: p_t.sy, ex: p_l.ex, ey: p_l.ey};
            two_in  = 1'b1;
         end
         default: seg0_in = '{sx: p_l.sx, sy: p_l.sy, ex: p_b.ex, ey: p_b.ey};
      endcase
      code_in = info.code;

      last      = ~two_ff | beat_ff;
      take      = vld_ff & ~rsp_stall;
      stat.hold = vld_ff & ~(take & last);
      load      = ~stat.hold & tail_vld;

      vld_in  = vld_ff;
      beat_in = beat_ff;
      if (load) begin
         vld_in  = 1'b1;
         beat_in = 1'b0;
      end else if (take & last) begin
         vld_in  = 1'b0;
         beat_in = 1'b0;
      end else if (take) begin
         beat_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff  <= 1'b0;
         beat_ff <= 1'b0;
      end else begin
         vld_ff  <= vld_in;
         beat_ff <= beat_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         seg0_ff <= seg0_in;
         seg1_ff <= seg1_in;
         two_ff  <= two_in;
         code_ff <= code_in;
      end
   end

   assign rsp_valid        = vld_ff;
   assign rsp_start_x      = beat_ff ? seg1_ff.sx : seg0_ff.sx;
   assign rsp_start_y      = beat_ff ? seg1_ff.sy : seg0_ff.sy;
   assign rsp_end_x        = beat_ff ? seg1_ff.ex : seg0_ff.ex;
   assign rsp_end_y        = beat_ff ? seg1_ff.ey : seg0_ff.ey;
   assign rsp_case_code    = code_ff;
   assign rsp_last_segment = last;

   `MSQ_ASSERT_NOW(a_first_beat_saddle, rsp_valid && !rsp_last_segment,
      rsp_case_code == CASE_SADDLE_A || rsp_case_code == CASE_SADDLE_B,
      "non-last beat on a cell that is not a saddle")
   `MSQ_ASSERT_NEXT(a_second_beat_follows, rsp_valid && !rsp_stall && !rsp_last_segment,
      rsp_valid && rsp_last_segment, "second saddle beat missing")
   `MSQ_ASSERT_NOW(a_no_empty_case, rsp_valid,
      rsp_case_code != CASE_NONE && rsp_case_code != CASE_ALL,
      "beat emitted for a cell with no crossing")

endmodule
